// ===== rtl/cu_pkg.sv =====
// ----------------------------------------------------------------------------
// cu_pkg
// Shared types, binary32 constants and round-to-nearest-even multiply and
// add helpers for the cosine pipeline.
// ----------------------------------------------------------------------------
package cu_pkg;

    typedef logic [31:0] fp32_t;

    typedef struct packed {
        logic       nan;
        logic [1:0] quad;
    } cu_tag_t;

    localparam int unsigned LAT = 22;

    localparam fp32_t QNAN_POS    = 32'h7FC0_0000;
    localparam fp32_t QNAN_NEG    = 32'hFFC0_0000;
    localparam fp32_t TWO_OVER_PI = 32'h3F22_F984;
    localparam fp32_t HALFPI_HEAD = 32'h3FC9_0F80;
    localparam fp32_t HALFPI_TAIL = 32'h3735_4443;
    localparam fp32_t CC7         = 32'hAD47_D74E;

    localparam fp32_t COS_COEF [0:6] = '{
        32'h310F_74F6, 32'hB493_F27C, 32'h37D0_0D01, 32'hBAB6_0B61,
        32'h3D2A_AAAB, 32'hBF00_0000, 32'h3F80_0000
    };

    localparam fp32_t SIN_COEF [0:6] = '{
        32'h2F2E_C9D3, 32'hB2D7_2F34, 32'h3638_EF1B, 32'hB950_0D01,
        32'h3C08_8889, 32'hBE2A_AAAB, 32'h3F80_0000
    };

    function automatic logic [5:0] lzc48(logic [47:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) n = 6'(47 - i);
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc27(logic [26:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 27; i++) begin
            if (v[i]) n = 5'(26 - i);
        end
        return n;
    endfunction

    function automatic fp32_t fp_mul(fp32_t a, fp32_t b);
        logic              sgn;
        logic              a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic [7:0]        ea, eb;
        logic [23:0]       ma, mb;
        logic [47:0]       prod, mn, v;
        logic [5:0]        lz, sh;
        logic signed [10:0] e, sh_full;
        logic              st, rnd;
        logic [30:0]       mag;
        fp32_t             res;
        sgn    = a[31] ^ b[31];
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma     = {a[30:23] != 8'd0, a[22:0]};
        mb     = {b[30:23] != 8'd0, b[22:0]};
        prod   = ma * mb;
        lz     = lzc48(prod);
        mn     = prod << lz;
        e      = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd126
                 - $signed({5'b0, lz});
        v      = mn;
        st     = 1'b0;
        sh     = 6'd0;
        sh_full = 11'sd0;
        mag    = 31'd0;
        rnd    = 1'b0;
        if (a_nan) begin
            res = a | 32'h0040_0000;
        end else if (b_nan) begin
            res = b | 32'h0040_0000;
        end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
            res = QNAN_NEG;
        end else if (a_inf || b_inf) begin
            res = {sgn, 8'hFF, 23'd0};
        end else if (prod == 48'd0) begin
            res = {sgn, 31'd0};
        end else if (e >= 11'sd255) begin
            res = {sgn, 8'hFF, 23'd0};
        end else begin
            if (e < 11'sd1) begin
                sh_full = 11'sd1 - e;
                if (sh_full > 11'sd47) begin
                    st = |mn;
                    v  = 48'd0;
                end else begin
                    sh = sh_full[5:0];
                    v  = mn >> sh;
                    st = |(mn & ~({48{1'b1}} << sh));
                end
                e = 11'sd1;
            end
            rnd = v[23] & (st | (|v[22:0]) | v[24]);
            mag = {e[7:0] - 8'd1, 23'd0} + {7'd0, v[47:24]} + {30'd0, rnd};
            res = {sgn, mag};
        end
        return res;
    endfunction

    function automatic fp32_t fp_add(fp32_t a, fp32_t b);
        logic              a_nan, b_nan, a_inf, b_inf;
        fp32_t             x, y, res;
        logic [7:0]        ex, ey, d;
        logic [26:0]       ax, by, by_s, m;
        logic [27:0]       s;
        logic [4:0]        lz, sh;
        logic [9:0]        e;
        logic              st, rnd;
        logic [30:0]       mag;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        if (b[30:0] > a[30:0]) begin
            x = b;
            y = a;
        end else begin
            x = a;
            y = b;
        end
        ex   = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey   = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d    = ex - ey;
        ax   = {x[30:23] != 8'd0, x[22:0], 3'b000};
        by   = {y[30:23] != 8'd0, y[22:0], 3'b000};
        if (d >= 8'd27) begin
            st   = |by;
            by_s = 27'd0;
        end else begin
            st   = |(by & ~({27{1'b1}} << d[4:0]));
            by_s = by >> d[4:0];
        end
        by_s[0] = by_s[0] | st;
        if (x[31] == y[31]) begin
            s = {1'b0, ax} + {1'b0, by_s};
        end else begin
            s = {1'b0, ax} - {1'b0, by_s};
        end
        e   = {2'b0, ex};
        lz  = 5'd0;
        sh  = 5'd0;
        m   = s[26:0];
        rnd = 1'b0;
        mag = 31'd0;
        if (a_nan) begin
            res = a | 32'h0040_0000;
        end else if (b_nan) begin
            res = b | 32'h0040_0000;
        end else if (a_inf && b_inf) begin
            res = (a[31] == b[31]) ? a : QNAN_NEG;
        end else if (a_inf) begin
            res = a;
        end else if (b_inf) begin
            res = b;
        end else if (s == 28'd0) begin
            res = {(x[31] == y[31]) ? x[31] : 1'b0, 31'd0};
        end else begin
            if (s[27]) begin
                m = {s[27:2], s[1] | s[0]};
                e = e + 10'd1;
            end else begin
                lz = lzc27(s[26:0]);
                sh = ({5'd0, lz} < (e - 10'd1)) ? lz : 5'((e - 10'd1));
                m  = s[26:0] << sh;
                e  = e - {5'd0, sh};
            end
            if (e >= 10'd255) begin
                res = {x[31], 8'hFF, 23'd0};
            end else begin
                rnd = m[2] & (m[1] | m[0] | m[3]);
                mag = {e[7:0] - 8'd1, 23'd0} + {7'd0, m[26:3]} + {30'd0, rnd};
                res = {x[31], mag};
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/cu_fmul.sv =====
// ----------------------------------------------------------------------------
// cu_fmul
// One registered binary32 multiply stage, round to nearest even.
// ----------------------------------------------------------------------------
module cu_fmul (
    input  logic            aclk,
    input  logic            en,
    input  cu_pkg::fp32_t   a,
    input  cu_pkg::fp32_t   b,
    output cu_pkg::fp32_t   y
);
    import cu_pkg::*;

    fp32_t y_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= fp_mul(a, b);
        end
    end

    assign y = y_reg;

endmodule

// ===== rtl/cu_fadd.sv =====
// ----------------------------------------------------------------------------
// cu_fadd
// One registered binary32 add stage, round to nearest even.
// ----------------------------------------------------------------------------
module cu_fadd (
    input  logic            aclk,
    input  logic            en,
    input  cu_pkg::fp32_t   a,
    input  cu_pkg::fp32_t   b,
    output cu_pkg::fp32_t   y
);
    import cu_pkg::*;

    fp32_t y_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= fp_add(a, b);
        end
    end

    assign y = y_reg;

endmodule

// ===== rtl/cu_reduce.sv =====
// ----------------------------------------------------------------------------
// cu_reduce
// Argument reduction: quotient by 2/pi, truncation, two-part subtraction of
// the quotient times pi/2, then the square of the reduced angle. Six stages.
// ----------------------------------------------------------------------------
module cu_reduce (
    input  logic             aclk,
    input  logic             en,
    input  logic [31:0]      angle_bits,
    output cu_pkg::fp32_t    r,
    output cu_pkg::fp32_t    z,
    output cu_pkg::cu_tag_t  tag
);
    import cu_pkg::*;

    fp32_t   t_in;
    logic    nan_in;
    fp32_t   p1;
    fp32_t   t1_reg, t2_reg, t3_reg;
    logic    nan1_reg;
    fp32_t   fq_next, fq2_reg;
    logic [1:0] quad_next;
    logic [31:0] n_int;
    logic [7:0]  k_exp;
    cu_tag_t tag2_reg, tag3_reg, tag4_reg, tag5_reg, tag6_reg;
    fp32_t   m1, m2, m2_4_reg, d1, r5, r6_reg;

    assign t_in   = {1'b0, angle_bits[30:0]};
    assign nan_in = (angle_bits[30:0] >= 31'h7F80_0000);

    cu_fmul u_mul_p (.aclk(aclk), .en(en), .a(t_in), .b(TWO_OVER_PI), .y(p1));

    always_comb begin
        k_exp = p1[30:23] - 8'd127;
        n_int = 32'd0;
        if (p1[30:23] < 8'd127) begin
            fq_next   = 32'd0;
            quad_next = 2'd0;
        end else if (p1[30:23] >= 8'd159) begin
            fq_next   = p1;
            quad_next = 2'd0;
        end else if (k_exp <= 8'd23) begin
            fq_next   = p1 & ({32{1'b1}} << (5'd23 - k_exp[4:0]));
            n_int     = {9'd1, p1[22:0]} >> (5'd23 - k_exp[4:0]);
            quad_next = n_int[1:0];
        end else begin
            fq_next   = p1;
            n_int     = {9'd1, p1[22:0]} << (k_exp[4:0] - 5'd23);
            quad_next = n_int[1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg   <= t_in;
            nan1_reg <= nan_in;
            t2_reg   <= t1_reg;
            fq2_reg  <= fq_next;
            tag2_reg <= '{nan: nan1_reg, quad: quad_next};
            t3_reg   <= t2_reg;
            tag3_reg <= tag2_reg;
            m2_4_reg <= m2;
            tag4_reg <= tag3_reg;
            tag5_reg <= tag4_reg;
            r6_reg   <= r5;
            tag6_reg <= tag5_reg;
        end
    end

    cu_fmul u_mul_head (.aclk(aclk), .en(en), .a(fq2_reg), .b(HALFPI_HEAD), .y(m1));
    cu_fmul u_mul_tail (.aclk(aclk), .en(en), .a(fq2_reg), .b(HALFPI_TAIL), .y(m2));
    cu_fadd u_sub_head (.aclk(aclk), .en(en), .a(t3_reg),
                        .b({~m1[31], m1[30:0]}), .y(d1));
    cu_fadd u_sub_tail (.aclk(aclk), .en(en), .a(d1),
                        .b({~m2_4_reg[31], m2_4_reg[30:0]}), .y(r5));
    cu_fmul u_mul_sq (.aclk(aclk), .en(en), .a(r5), .b(r5), .y(z));

    assign r   = r6_reg;
    assign tag = tag6_reg;

endmodule

// ===== rtl/cu_poly.sv =====
// ----------------------------------------------------------------------------
// cu_poly
// Cosine and sine Horner kernels side by side, one multiply stage and one add
// stage per term, then the closing multiply of the sine lane by r.
// ----------------------------------------------------------------------------
module cu_poly (
    input  logic             aclk,
    input  logic             en,
    input  cu_pkg::fp32_t    r,
    input  cu_pkg::fp32_t    z,
    input  cu_pkg::cu_tag_t  tag_in,
    output cu_pkg::fp32_t    cos_k,
    output cu_pkg::fp32_t    sin_k,
    output cu_pkg::cu_tag_t  tag_out
);
    import cu_pkg::*;

    fp32_t   ac [0:7];
    fp32_t   as [1:7];
    fp32_t   zs [0:6];
    fp32_t   rs [0:7];
    cu_tag_t tg [0:7];
    fp32_t   cos_reg;
    cu_tag_t tag_reg;

    assign ac[0] = CC7;
    assign zs[0] = z;
    assign rs[0] = r;
    assign tg[0] = tag_in;
    assign as[1] = SIN_COEF[0];

    for (genvar j = 0; j < 7; j++) begin : g_step
        fp32_t   pc;
        fp32_t   r_mid_reg, r_out_reg;
        cu_tag_t tg_mid_reg, tg_out_reg;

        cu_fmul u_mul_c (.aclk(aclk), .en(en), .a(zs[j]), .b(ac[j]), .y(pc));
        cu_fadd u_add_c (.aclk(aclk), .en(en), .a(COS_COEF[j]), .b(pc), .y(ac[j+1]));

        always_ff @(posedge aclk) begin
            if (en) begin
                r_mid_reg  <= rs[j];
                r_out_reg  <= r_mid_reg;
                tg_mid_reg <= tg[j];
                tg_out_reg <= tg_mid_reg;
            end
        end

        assign rs[j+1] = r_out_reg;
        assign tg[j+1] = tg_out_reg;

        if (j < 6) begin : g_z
            fp32_t z_mid_reg, z_out_reg;
            always_ff @(posedge aclk) begin
                if (en) begin
                    z_mid_reg <= zs[j];
                    z_out_reg <= z_mid_reg;
                end
            end
            assign zs[j+1] = z_out_reg;
        end

        if (j > 0) begin : g_sin
            fp32_t ps;
            cu_fmul u_mul_s (.aclk(aclk), .en(en), .a(zs[j]), .b(as[j]), .y(ps));
            cu_fadd u_add_s (.aclk(aclk), .en(en), .a(SIN_COEF[j]), .b(ps),
                             .y(as[j+1]));
        end
    end

    cu_fmul u_mul_r (.aclk(aclk), .en(en), .a(rs[7]), .b(as[7]), .y(sin_k));

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= ac[7];
            tag_reg <= tg[7];
        end
    end

    assign cos_k   = cos_reg;
    assign tag_out = tag_reg;

endmodule

// ===== rtl/binary32_cosine_unit.sv =====
// ----------------------------------------------------------------------------
// binary32_cosine_unit
// Streaming binary32 cosine: range reduction by pi/2 and polynomial kernels.
// ----------------------------------------------------------------------------
// Takes one item per cycle unless held by m_tready; its cosine passes six stages
// of range reduction, fourteen stages of the Horner kernels (one rounded
// multiply and one rounded add per term), the closing sine multiply and the
// output register with the quadrant sign. The whole pipeline moves together
// and holds while a finished item waits on m_tready. NaN or infinite angles
// give the quiet NaN 0x7FC00000.
module binary32_cosine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] angle_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] cosine_bits
);
    import cu_pkg::*;

    logic            en;
    logic [LAT-1:0]  vld_reg, vld_next;
    fp32_t           r6, z6, cos_k, sin_k, k_sel;
    cu_tag_t         tag6, tag_k;
    fp32_t           out_reg, out_next;
    logic            s_fire, m_fire;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign vld_next = {vld_reg[LAT-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    cu_reduce u_reduce (
        .aclk(aclk), .en(en), .angle_bits(s_tdata),
        .r(r6), .z(z6), .tag(tag6)
    );

    cu_poly u_poly (
        .aclk(aclk), .en(en), .r(r6), .z(z6), .tag_in(tag6),
        .cos_k(cos_k), .sin_k(sin_k), .tag_out(tag_k)
    );

    always_comb begin
        k_sel = tag_k.quad[0] ? sin_k : cos_k;
        if (tag_k.nan) begin
            out_next = QNAN_POS;
        end else if (tag_k.quad == 2'd1 || tag_k.quad == 2'd2) begin
            out_next = {~k_sel[31], k_sel[30:0]};
        end else begin
            out_next = k_sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = out_reg;

    assign s_fire = aresetn && s_tvalid && s_tready;
    assign m_fire = aresetn && m_tvalid && m_tready;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    a_item_count: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> $countones(vld_reg) ==
            $past($countones(vld_reg)) + $past(32'(s_fire)) - $past(32'(m_fire)))
        else $error("item lost or duplicated in pipeline");

endmodule
